[hw/rtl/scea_pkg.sv]
package scea_pkg;

  localparam int SUM_BITS = 40;
  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  localparam int COORD_BITS = 24;
  localparam int RADIUS_BITS = 10;
  localparam int SHRINK_BITS = 8;
  localparam int MARGIN_BITS = 10;
  localparam int CFG_DATA_BITS = 10;

  // Register indexes on the configuration port.
  localparam logic CFG_RADIUS_SHRINK = 1'b0;
  localparam logic CFG_SEARCH_MARGIN = 1'b1;

  localparam logic [SHRINK_BITS-1:0] SHRINK_RESET = 8'd64;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 10'd435;

  // Scoring constants: 10.0 in Q.8, 0.8254 as 4127/5000 with the denominator squared, slope 57.273.
  localparam logic [11:0] SCORE_FULL = 12'd2560;
  localparam logic [24:0] INNER_DEN_SQ = 25'd25000000;
  localparam logic [12:0] INNER_NUM_ROOT = 13'd4127;
  localparam logic [15:0] SLOPE_NUM = 16'd57273;
  localparam logic [9:0] SLOPE_DEN = 10'd1000;
  localparam logic [8:0] SLOPE_HALF = 9'd500;

  localparam int ROOT_IN_BITS = 38;
  localparam int ROOT_OUT_BITS = 20;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
    logic signed [COORD_BITS-1:0] query_z;
    logic [RADIUS_BITS-1:0] query_radius;
    logic signed [COORD_BITS-1:0] neighbor_x;
    logic signed [COORD_BITS-1:0] neighbor_y;
    logic signed [COORD_BITS-1:0] neighbor_z;
    logic [RADIUS_BITS-1:0] neighbor_radius;
    logic last_pair;
  } pair_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] total_energy;
    logic overflowed;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_TEST,
    ST_INNER,
    ST_SQRT,
    ST_DIV,
    ST_ACC
  } state_t;

endpackage

[hw/rtl/steric_clash_energy_accumulator_unit.sv]
// Steric clash energy accumulator. Pairs are taken one at a time: a pair occupies the
// block until it leaves ST_ACC; a pair dropped or scored zero or full by the early
// tests skips the square root and the divider. The long path goes through the
// bit-serial square root (19 root steps and the hand-off) and the restoring divider
// that turns the distance into a score. The total leaves through an output register,
// so a new pair is taken while an earlier total still waits; a last pair whose total
// finds that register still full waits for it to drain. Configuration is read in ST_SQR.
module steric_clash_energy_accumulator_unit (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  scea_pkg::pair_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output scea_pkg::result_t out_data,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [scea_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int SB = scea_pkg::SUM_BITS;

  scea_pkg::state_t state_r, state_nxt;

  logic [scea_pkg::SHRINK_BITS-1:0] shrink_r;
  logic [scea_pkg::MARGIN_BITS-1:0] margin_r;

  logic [10:0] mx_r, my_r, mz_r, mx_nxt, my_nxt, mz_nxt;
  logic big_r, big_nxt;
  logic [9:0] qr_r, nr_r, qr_nxt, nr_nxt;
  logic last_r, last_nxt;
  logic [23:0] d2_r, d2_nxt;
  logic [21:0] cut2_r, cut2_nxt;
  logic [10:0] rr_r, rr_nxt;
  logic [21:0] rr2_r, rr2_nxt;
  logic [22:0] k_r, k_nxt;
  logic [46:0] pa_r, pa_nxt;
  logic [45:0] pb_r, pb_nxt;
  logic [11:0] score_r, score_nxt;
  logic [35:0] rem_r, rem_nxt;
  logic [31:0] dsh_r, dsh_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [SB-1:0] sum_r, sum_nxt;
  logic sat_r, sat_nxt;
  logic out_valid_r, out_valid_nxt;
  scea_pkg::result_t out_data_r, out_data_nxt;

  logic in_xfer;
  logic sq_start, sq_done;
  logic [scea_pkg::ROOT_OUT_BITS-1:0] sq_root;

  logic [24:0] dx, dy, dz, ax, ay, az;
  logic [9:0] qs, ns;
  logic [10:0] cut;
  logic [18:0] rr16, dq, e;
  logic [34:0] slope_prod;
  logic [SB:0] sum_wide;
  logic [SB-1:0] sum_upd;
  logic sat_upd;

  scea_isqrt u_isqrt (
    .clk(clk),
    .rst_n(rst_n),
    .start(sq_start),
    .radicand({d2_r[21:0], 16'b0}),
    .done(sq_done),
    .root(sq_root)
  );

  assign in_stall = (state_r != scea_pkg::ST_IDLE);
  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    dx = {in_data.query_x[23], in_data.query_x} - {in_data.neighbor_x[23], in_data.neighbor_x};
    dy = {in_data.query_y[23], in_data.query_y} - {in_data.neighbor_y[23], in_data.neighbor_y};
    dz = {in_data.query_z[23], in_data.query_z} - {in_data.neighbor_z[23], in_data.neighbor_z};
    ax = dx[24] ? -dx : dx;
    ay = dy[24] ? -dy : dy;
    az = dz[24] ? -dz : dz;
    qs = (qr_r > 10'(shrink_r)) ? qr_r - 10'(shrink_r) : 10'd0;
    ns = (nr_r > 10'(shrink_r)) ? nr_r - 10'(shrink_r) : 10'd0;
    cut = 11'(qr_r) + 11'(margin_r);
    rr16 = {rr_r, 8'b0};
    dq = (20'(rr16) < sq_root) ? rr16 : sq_root[18:0];
    e = rr16 - dq;
    slope_prod = 35'(scea_pkg::SLOPE_NUM) * 35'(e);
    sum_wide = {1'b0, sum_r} + (SB + 1)'(score_r);
    if (sum_wide > {1'b0, scea_pkg::SUM_MAX}) begin
      sum_upd = scea_pkg::SUM_MAX;
      sat_upd = 1'b1;
    end else begin
      sum_upd = sum_wide[SB-1:0];
      sat_upd = sat_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sq_start = 1'b0;
    mx_nxt = mx_r;
    my_nxt = my_r;
    mz_nxt = mz_r;
    big_nxt = big_r;
    qr_nxt = qr_r;
    nr_nxt = nr_r;
    last_nxt = last_r;
    d2_nxt = d2_r;
    cut2_nxt = cut2_r;
    rr_nxt = rr_r;
    rr2_nxt = rr2_r;
    k_nxt = k_r;
    pa_nxt = pa_r;
    pb_nxt = pb_r;
    score_nxt = score_r;
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    sat_nxt = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    unique case (state_r)
      scea_pkg::ST_IDLE: begin
        if (in_xfer) begin
          mx_nxt = ax[10:0];
          my_nxt = ay[10:0];
          mz_nxt = az[10:0];
          // Any axis past 2047 puts the pair beyond every possible cutoff.
          big_nxt = (|ax[24:11]) || (|ay[24:11]) || (|az[24:11]);
          qr_nxt = in_data.query_radius;
          nr_nxt = in_data.neighbor_radius;
          last_nxt = in_data.last_pair;
          state_nxt = scea_pkg::ST_SQR;
        end
      end
      scea_pkg::ST_SQR: begin
        d2_nxt = 24'(22'(mx_r) * 22'(mx_r)) + 24'(22'(my_r) * 22'(my_r))
               + 24'(22'(mz_r) * 22'(mz_r));
        cut2_nxt = 22'(cut) * 22'(cut);
        rr_nxt = 11'(qs) + 11'(ns);
        rr2_nxt = 22'(11'(qs) + 11'(ns)) * 22'(11'(qs) + 11'(ns));
        k_nxt = 23'(scea_pkg::INNER_NUM_ROOT) * 23'(11'(qs) + 11'(ns));
        state_nxt = scea_pkg::ST_TEST;
      end
      scea_pkg::ST_TEST: begin
        pa_nxt = 47'(d2_r[21:0]) * 47'(scea_pkg::INNER_DEN_SQ);
        pb_nxt = 46'(k_r) * 46'(k_r);
        score_nxt = '0;
        if (big_r || (d2_r > 24'(cut2_r)) || (rr_r == '0) || (d2_r > 24'(rr2_r))) begin
          state_nxt = scea_pkg::ST_ACC;
        end else begin
          state_nxt = scea_pkg::ST_INNER;
        end
      end
      scea_pkg::ST_INNER: begin
        if (pa_r < 47'(pb_r)) begin
          score_nxt = scea_pkg::SCORE_FULL;
          state_nxt = scea_pkg::ST_ACC;
        end else begin
          sq_start = 1'b1;
          state_nxt = scea_pkg::ST_SQRT;
        end
      end
      scea_pkg::ST_SQRT: begin
        if (sq_done) begin
          // Rounded quotient: (57273*e + 500*rr) / (1000*rr), the Q.8 scale cancels.
          rem_nxt = 36'(slope_prod) + 36'(20'(scea_pkg::SLOPE_HALF) * 20'(rr_r));
          dsh_nxt = 32'(21'(scea_pkg::SLOPE_DEN) * 21'(rr_r)) << 11;
          cnt_nxt = 4'd11;
          score_nxt = '0;
          state_nxt = scea_pkg::ST_DIV;
        end
      end
      scea_pkg::ST_DIV: begin
        if (rem_r >= 36'(dsh_r)) begin
          rem_nxt = rem_r - 36'(dsh_r);
          score_nxt = {score_r[10:0], 1'b1};
        end else begin
          score_nxt = {score_r[10:0], 1'b0};
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = scea_pkg::ST_ACC;
        end
      end
      scea_pkg::ST_ACC: begin
        if (!last_r) begin
          sum_nxt = sum_upd;
          sat_nxt = sat_upd;
          state_nxt = scea_pkg::ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.total_energy = sum_upd;
          out_data_nxt.overflowed = sat_upd;
          sum_nxt = '0;
          sat_nxt = 1'b0;
          state_nxt = scea_pkg::ST_IDLE;
        end
      end
      default: state_nxt = scea_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scea_pkg::ST_IDLE;
      shrink_r <= scea_pkg::SHRINK_RESET;
      margin_r <= scea_pkg::MARGIN_RESET;
      sum_r <= '0;
      sat_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt;
      sat_r <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        priority if (cfg_index == scea_pkg::CFG_RADIUS_SHRINK) begin
          shrink_r <= cfg_wdata[scea_pkg::SHRINK_BITS-1:0];
        end else if (cfg_index == scea_pkg::CFG_SEARCH_MARGIN) begin
          margin_r <= cfg_wdata[scea_pkg::MARGIN_BITS-1:0];
        end
      end
    end
    mx_r <= mx_nxt;
    my_r <= my_nxt;
    mz_r <= mz_nxt;
    big_r <= big_nxt;
    qr_r <= qr_nxt;
    nr_r <= nr_nxt;
    last_r <= last_nxt;
    d2_r <= d2_nxt;
    cut2_r <= cut2_nxt;
    rr_r <= rr_nxt;
    rr2_r <= rr2_nxt;
    k_r <= k_nxt;
    pa_r <= pa_nxt;
    pb_r <= pb_nxt;
    score_r <= score_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    cnt_r <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == scea_pkg::ST_ACC && last_r))
    else $error("total transfer not caused by a last pair");

  a_sat_holds_max: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (sum_r == scea_pkg::SUM_MAX))
    else $error("saturated sum is not at its maximum");

  a_score_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == scea_pkg::ST_ACC) |-> (score_r <= 12'd2700))
    else $error("pair score out of range");

endmodule

[hw/rtl/scea_isqrt.sv]
module scea_isqrt (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [scea_pkg::ROOT_IN_BITS-1:0] radicand,
  output logic done,
  output logic [scea_pkg::ROOT_OUT_BITS-1:0] root
);

  localparam int W = scea_pkg::ROOT_IN_BITS;

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] root_r, root_nxt;
  logic [W-1:0] bit_r, bit_nxt;
  logic [W-1:0] trial;

  // One result bit per cycle: the trial bit walks down two places at a time.
  always_comb begin
    trial = root_r + bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt = rem_r;
    root_nxt = root_r;
    bit_nxt = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt = radicand;
      root_nxt = '0;
      bit_nxt = W'(1) << (W - 2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = root_r[scea_pkg::ROOT_OUT_BITS-1:0];

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 48;
  localparam int CW = scea_pkg::COORD_BITS;
  localparam int RW = scea_pkg::RADIUS_BITS;
  localparam int SW = scea_pkg::SHRINK_BITS;
  localparam int MW = scea_pkg::MARGIN_BITS;
  localparam int DW = scea_pkg::CFG_DATA_BITS;
  localparam int SB = scea_pkg::SUM_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  scea_pkg::pair_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  scea_pkg::result_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = scea_pkg::CFG_RADIUS_SHRINK;
  logic [DW-1:0] cfg_wdata = '0;

  // Local copy of the block's registers and running sum.
  logic [SW-1:0] shrink_amt;
  logic [MW-1:0] margin_amt;
  longint unsigned running_sum;
  bit running_sat;
  scea_pkg::result_t totals_due[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  always #4 clk = ~clk;

  steric_clash_energy_accumulator_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic longint unsigned axis_sq(logic [CW-1:0] a, logic [CW-1:0] b);
    longint signed diff;
    diff = longint'($signed(a)) - longint'($signed(b));
    if (diff < 0) diff = -diff;
    return longint'(diff) * longint'(diff);
  endfunction

  function automatic longint unsigned shrunk(logic [RW-1:0] r);
    return (r > shrink_amt) ? longint'(r) - longint'(shrink_amt) : 0;
  endfunction

  function automatic longint unsigned predict_score(scea_pkg::pair_t p);
    longint unsigned d2, cut, rr, rr2, rr16, dq, val, bitpos, num, den;
    d2 = axis_sq(p.query_x, p.neighbor_x) + axis_sq(p.query_y, p.neighbor_y) +
         axis_sq(p.query_z, p.neighbor_z);
    cut = longint'(p.query_radius) + longint'(margin_amt);
    if (d2 > cut * cut) return 0;
    rr = shrunk(p.query_radius) + shrunk(p.neighbor_radius);
    if (rr == 0) return 0;
    rr2 = rr * rr;
    if (d2 > rr2) return 0;
    if (d2 * 64'd100000000 < 64'd68128516 * rr2) return 2560;
    // Bit-pair integer square root of the squared distance in Q.16, giving the distance in Q.8.
    val = d2 << 16;
    dq = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > val) bitpos >>= 2;
    while (bitpos != 0) begin
      if (val >= dq + bitpos) begin
        val -= dq + bitpos;
        dq = (dq >> 1) + bitpos;
      end else begin
        dq >>= 1;
      end
      bitpos >>= 2;
    end
    rr16 = rr << 8;
    if (dq > rr16) dq = rr16;
    num = 64'd57273 * (rr16 - dq) * 256;
    den = 64'd1000 * rr16;
    return (num + den / 2) / den;
  endfunction

  function automatic void accumulate_pair(scea_pkg::pair_t p);
    longint unsigned s, top;
    scea_pkg::result_t r;
    s = predict_score(p);
    top = longint'(scea_pkg::SUM_MAX);
    if (running_sum > top - s) begin
      running_sum = top;
      running_sat = 1'b1;
    end else begin
      running_sum += s;
    end
    if (p.last_pair) begin
      r.total_energy = running_sum[SB-1:0];
      r.overflowed = running_sat;
      totals_due.push_back(r);
      running_sum = 0;
      running_sat = 1'b0;
    end
  endfunction

  task automatic send_pair(scea_pkg::pair_t p);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_pair(p);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (totals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Upper data bits of a shrink write are randomized so that bits beyond its width are exercised.
  task automatic write_reg(logic idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= DW'(value) | (idx == scea_pkg::CFG_RADIUS_SHRINK ?
                 DW'($urandom_range(3) << SW) : '0);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == scea_pkg::CFG_RADIUS_SHRINK) shrink_amt = SW'(value);
    else margin_amt = MW'(value);
    @(posedge clk);
  endtask

  function automatic logic [CW-1:0] nudge(logic [CW-1:0] c, int reach);
    return c + CW'($urandom_range(0, 2 * reach) - reach);
  endfunction

  function automatic scea_pkg::pair_t random_pair(bit last);
    scea_pkg::pair_t p;
    int pick, reach;
    p.query_x = CW'($urandom());
    p.query_y = CW'($urandom());
    p.query_z = CW'($urandom());
    p.query_radius = RW'($urandom());
    p.neighbor_radius = RW'($urandom());
    p.last_pair = last;
    pick = $urandom_range(99);
    if (pick < 15) begin
      p.neighbor_x = CW'($urandom());
      p.neighbor_y = CW'($urandom());
      p.neighbor_z = CW'($urandom());
    end else begin
      reach = (pick < 35) ? 120 : 700;
      p.neighbor_x = nudge(p.query_x, reach);
      p.neighbor_y = nudge(p.query_y, reach);
      p.neighbor_z = nudge(p.query_z, reach);
    end
    return p;
  endfunction

  function automatic scea_pkg::pair_t placed_pair(int qr, int nr, int dx, int dy, int dz,
                                                  bit last);
    scea_pkg::pair_t p;
    p = '0;
    p.query_radius = RW'(qr);
    p.neighbor_radius = RW'(nr);
    p.neighbor_x = CW'(dx);
    p.neighbor_y = CW'(dy);
    p.neighbor_z = CW'(dz);
    p.last_pair = last;
    return p;
  endfunction

  task automatic test_directed();
    scea_pkg::pair_t p;
    // Coincident atoms with zero radii score nothing.
    send_pair(placed_pair(0, 0, 0, 0, 0, 1'b1));
    // Both radii below the shrink amount.
    send_pair(placed_pair(40, 63, 10, 0, 0, 1'b1));
    // Deep overlap, two partial overlaps, and a pair inside the radius sum but beyond the cutoff.
    send_pair(placed_pair(512, 512, 100, 0, 0, 1'b0));
    send_pair(placed_pair(512, 512, 700, 0, 0, 1'b0));
    send_pair(placed_pair(512, 512, 0, 800, 0, 1'b0));
    send_pair(placed_pair(1023, 1023, 0, 0, 1900, 1'b1));
    // Exactly at the cutoff is kept; one step beyond is dropped.
    send_pair(placed_pair(300, 1023, 735, 0, 0, 1'b0));
    send_pair(placed_pair(300, 1023, 736, 0, 0, 1'b1));
    // Dropped last pair still emits the total.
    send_pair(placed_pair(512, 512, 300, 0, 0, 1'b0));
    send_pair(placed_pair(512, 512, 0, 0, 5000, 1'b1));
    // Coordinate extremes on every axis.
    p = placed_pair(1023, 1023, 0, 0, 0, 1'b1);
    p.query_x = 24'h800000; p.query_y = 24'h7fffff; p.query_z = 24'h800000;
    p.neighbor_x = 24'h7fffff; p.neighbor_y = 24'h800000; p.neighbor_z = 24'h7fffff;
    send_pair(p);
    p.neighbor_x = 24'h800001; p.neighbor_y = 24'h7ffffe; p.neighbor_z = 24'h800000;
    send_pair(p);
    wait_idle();
  endtask

  task automatic test_register_sweep();
    int shrinks[4] = '{0, 255, 64, 17};
    int margins[4] = '{1023, 0, 512, 435};
    for (int k = 0; k < 4; k++) begin
      write_reg(scea_pkg::CFG_RADIUS_SHRINK, shrinks[k]);
      write_reg(scea_pkg::CFG_SEARCH_MARGIN, margins[k]);
      for (int n = 0; n < 40; n++) send_pair(random_pair(n % 5 == 4));
      wait_idle();
    end
  endtask

  task automatic test_random_sets();
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(scea_pkg::CFG_RADIUS_SHRINK, $urandom_range(255));
      write_reg(scea_pkg::CFG_SEARCH_MARGIN, $urandom_range(1023));
      for (int n = 0; n < 450; n++) begin
        no_idle = (phase == 2 && n >= 100 && n < 350);
        send_pair(random_pair($urandom_range(7) == 0 || n == 449));
      end
      no_idle = 1'b0;
      wait_idle();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (totals_due.size() == 0) begin
        $error("unexpected total %0d", out_data.total_energy);
        errors++;
      end else begin
        scea_pkg::result_t want;
        want = totals_due.pop_front();
        if (out_data.total_energy !== want.total_energy) begin
          $error("total_energy: expected %0d, got %0d", want.total_energy,
                 out_data.total_energy);
          errors++;
        end
        if (out_data.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, got %0d", want.overflowed, out_data.overflowed);
          errors++;
        end
      end
    end
    out_stall <= !no_idle && $urandom_range(99) < 35;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("steric_clash_energy_accumulator_unit regression: fail");
      $finish;
    end
  end

  initial begin
    shrink_amt = scea_pkg::SHRINK_RESET;
    margin_amt = scea_pkg::MARGIN_RESET;
    running_sum = 0;
    running_sat = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_sweep();
    test_random_sets();
    if (errors == 0) begin
      $display("steric_clash_energy_accumulator_unit regression: pass");
    end else begin
      $display("steric_clash_energy_accumulator_unit regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/scea_pkg.sv
hw/rtl/scea_isqrt.sv
hw/rtl/steric_clash_energy_accumulator_unit.sv
tb/tb_top.sv
